// ===== hdl/gfsi_pkg.sv =====
// Shared constants and codes for the GF(2^m) share evaluation and interpolation core.
// No dependencies; used by every module of the block.
package gfsi_pkg;

   // Reduction polynomial, masked to the field width where it is applied
   localparam int FIELD_POLY = 'h11D;

   // Bits of the multiplier operand consumed per cycle
   localparam int MUL_DIGIT = 4;

   // Configuration register
   localparam int CSR_WIDTH = 5;
   localparam logic [CSR_WIDTH-1:0] COEFF_COUNT_RESET = 5'd2;

   // Field widths fixed by the interface
   localparam int CMD_WIDTH    = 3;
   localparam int SLOT_WIDTH   = 4;
   localparam int STATUS_WIDTH = 2;

   // Command codes
   localparam logic [CMD_WIDTH-1:0] CMD_SET_COEF = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_EVALUATE = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_ADD_POINT = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_INTERPOLATE = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR_POINTS = 3'd4;

   // Status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DUP  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd2;

endpackage

// ===== hdl/gfsi_mul.sv =====
// Digit-serial GF(2^m) multiplier shared by all field products of the core.
// Uses gfsi_pkg for the reduction polynomial and the digit size.
module gfsi_mul #(
   parameter int FIELD_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mul_start,
   input  logic [FIELD_BITS-1:0] mul_a,
   input  logic [FIELD_BITS-1:0] mul_b,
   output logic                  mul_done,
   output logic [FIELD_BITS-1:0] mul_prod
);

   localparam int DIGIT = gfsi_pkg::MUL_DIGIT;
   localparam int STEPS = (FIELD_BITS + DIGIT - 1) / DIGIT;
   localparam int PW    = STEPS * DIGIT;
   localparam int SC    = $clog2(STEPS + 1);
   localparam logic [FIELD_BITS-1:0] RED = FIELD_BITS'(gfsi_pkg::FIELD_POLY);

   logic [FIELD_BITS-1:0] a_ff, a_in;
   logic [PW-1:0]         b_sh_ff, b_sh_in;
   logic [FIELD_BITS-1:0] p_ff, p_in;
   logic [SC-1:0]         cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   // One digit of MSB-first shift-and-add with reduction
   function automatic logic [FIELD_BITS-1:0] digit_step(
      input logic [FIELD_BITS-1:0] p,
      input logic [FIELD_BITS-1:0] a,
      input logic [DIGIT-1:0]      bits
   );
      logic [FIELD_BITS-1:0] v;
      v = p;
      for (int d = DIGIT - 1; d >= 0; d--) begin
         v = {v[FIELD_BITS-2:0], 1'b0} ^ (v[FIELD_BITS-1] ? RED : '0);
         if (bits[d]) begin
            v = v ^ a;
         end
      end
      return v;
   endfunction

   // Load operands on start, then advance one digit per cycle
   always_comb begin
      a_in    = a_ff;
      b_sh_in = b_sh_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (mul_start) begin
         a_in    = mul_a;
         b_sh_in = PW'(mul_b);
         p_in    = '0;
         cnt_in  = SC'(STEPS);
      end else if (cnt_ff != '0) begin
         p_in    = digit_step(p_ff, a_ff, b_sh_ff[PW-1 -: DIGIT]);
         b_sh_in = b_sh_ff << DIGIT;
         cnt_in  = cnt_ff - SC'(1);
         done_in = (cnt_ff == SC'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_sh_ff <= b_sh_in;
      p_ff    <= p_in;
   end

   assign mul_done = done_ff;
   assign mul_prod = p_ff;

endmodule

// ===== hdl/gfsi_ctrl.sv =====
// Command sequencer with coefficient and point stores; drives the shared multiplier.
// Uses gfsi_pkg for command and status codes.
module gfsi_ctrl #(
   parameter int FIELD_BITS = 8,
   parameter int MAX_COEFFS = 16,
   parameter int MAX_POINTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [gfsi_pkg::CMD_WIDTH-1:0]      req_command,
   input  logic [gfsi_pkg::SLOT_WIDTH-1:0]     req_coef_slot,
   input  logic [FIELD_BITS-1:0]               req_point,
   input  logic [FIELD_BITS-1:0]               req_value,
   input  logic [$clog2(MAX_COEFFS+1)-1:0]     coeff_limit,
   output logic                                rsp_valid,
   output logic [FIELD_BITS-1:0]               rsp_result,
   output logic [gfsi_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic                                mul_start,
   output logic [FIELD_BITS-1:0]               mul_a,
   output logic [FIELD_BITS-1:0]               mul_b,
   input  logic                                mul_done,
   input  logic [FIELD_BITS-1:0]               mul_prod
);

   localparam int CW  = $clog2(MAX_COEFFS + 1);
   localparam int CA  = $clog2(MAX_COEFFS);
   localparam int PCW = $clog2(MAX_POINTS + 1);
   localparam int PA  = $clog2(MAX_POINTS);
   localparam int EW  = $clog2(FIELD_BITS);
   localparam int NS  = 22;

   typedef enum logic [NS-1:0] {
      S_IDLE    = NS'(1) << 0,
      S_EXEC    = NS'(1) << 1,
      S_ADD_RD  = NS'(1) << 2,
      S_ADD_CMP = NS'(1) << 3,
      S_ADD_PUT = NS'(1) << 4,
      S_EV_STEP = NS'(1) << 5,
      S_EV_ADD  = NS'(1) << 6,
      S_IP_RDI  = NS'(1) << 7,
      S_IP_LDI  = NS'(1) << 8,
      S_IP_JRD  = NS'(1) << 9,
      S_IP_JCHK = NS'(1) << 10,
      S_IP_NUM  = NS'(1) << 11,
      S_IP_DEN  = NS'(1) << 12,
      S_IP_INV0 = NS'(1) << 13,
      S_IP_SQ   = NS'(1) << 14,
      S_IP_SQD  = NS'(1) << 15,
      S_IP_INVM = NS'(1) << 16,
      S_IP_T1   = NS'(1) << 17,
      S_IP_T2   = NS'(1) << 18,
      S_IP_T3   = NS'(1) << 19,
      S_MUL_WT  = NS'(1) << 20,
      S_FINISH  = NS'(1) << 21
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   logic [gfsi_pkg::CMD_WIDTH-1:0]    cmd_ff, cmd_in;
   logic [gfsi_pkg::SLOT_WIDTH-1:0]   slot_ff, slot_in;
   logic [FIELD_BITS-1:0]             pt_ff, pt_in;
   logic [FIELD_BITS-1:0]             val_ff, val_in;
   logic [FIELD_BITS-1:0]             acc_ff, acc_in;
   logic [FIELD_BITS-1:0]             num_ff, num_in;
   logic [FIELD_BITS-1:0]             den_ff, den_in;
   logic [FIELD_BITS-1:0]             sq_ff, sq_in;
   logic [FIELD_BITS-1:0]             inv_ff, inv_in;
   logic [CW-1:0]                     k_ff, k_in;
   logic [PCW-1:0]                    i_ff, i_in;
   logic [PCW-1:0]                    j_ff, j_in;
   logic [PCW-1:0]                    count_ff, count_in;
   logic [EW-1:0]                     ecnt_ff, ecnt_in;
   logic [gfsi_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0]             rsp_result_ff, rsp_result_in;
   logic [gfsi_pkg::STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;

   // Stores and their registered read data
   logic [FIELD_BITS-1:0] coef_mem [MAX_COEFFS];
   logic [FIELD_BITS-1:0] xs_mem [MAX_POINTS];
   logic [FIELD_BITS-1:0] ys_mem [MAX_POINTS];
   logic [FIELD_BITS-1:0] coef_rd_ff;
   logic [FIELD_BITS-1:0] xi_rd_ff;
   logic [FIELD_BITS-1:0] xj_rd_ff;
   logic [FIELD_BITS-1:0] yi_rd_ff;
   logic                  coef_we;
   logic                  pt_we;

   logic j_last;
   logic i_last;

   assign busy   = (state_ff != S_IDLE);
   assign j_last = ((j_ff + PCW'(1)) == count_ff);
   assign i_last = ((i_ff + PCW'(1)) == count_ff);

   // Sequence one command through the shared multiplier
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      pt_in         = pt_ff;
      val_in        = val_ff;
      acc_in        = acc_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      sq_in         = sq_ff;
      inv_in        = inv_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      ecnt_in       = ecnt_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_result_in = rsp_result_ff;
      rsp_status_in = rsp_status_ff;
      mul_start     = 1'b0;
      mul_a         = acc_ff;
      mul_b         = pt_ff;
      coef_we       = 1'b0;
      pt_we         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               slot_in  = req_coef_slot;
               pt_in    = req_point;
               val_in   = req_value;
               state_in = S_EXEC;
            end
         end

         // Decode the command; clear the accumulator and status
         S_EXEC: begin
            acc_in    = '0;
            status_in = gfsi_pkg::STATUS_OK;
            j_in      = '0;
            i_in      = '0;
            state_in  = S_FINISH;
            case (cmd_ff)
               gfsi_pkg::CMD_SET_COEF: begin
                  coef_we = (32'(slot_ff) < MAX_COEFFS);
               end
               gfsi_pkg::CMD_EVALUATE: begin
                  k_in = coeff_limit;
                  if (coeff_limit != '0) begin
                     state_in = S_EV_STEP;
                  end
               end
               gfsi_pkg::CMD_ADD_POINT: begin
                  state_in = (count_ff == '0) ? S_ADD_PUT : S_ADD_RD;
               end
               gfsi_pkg::CMD_INTERPOLATE: begin
                  if (count_ff != '0) begin
                     state_in = S_IP_RDI;
                  end
               end
               gfsi_pkg::CMD_CLEAR_POINTS: begin
                  count_in = '0;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // Scan stored x values for a duplicate
         S_ADD_RD: begin
            state_in = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            if (xj_rd_ff == pt_ff) begin
               status_in = gfsi_pkg::STATUS_DUP;
               state_in  = S_FINISH;
            end else if (j_last) begin
               state_in = S_ADD_PUT;
            end else begin
               j_in     = j_ff + PCW'(1);
               state_in = S_ADD_RD;
            end
         end
         S_ADD_PUT: begin
            if (count_ff == PCW'(MAX_POINTS)) begin
               status_in = gfsi_pkg::STATUS_FULL;
            end else begin
               pt_we    = 1'b1;
               count_in = count_ff + PCW'(1);
            end
            state_in = S_FINISH;
         end

         // Horner step: acc = acc * x + c[k-1]
         S_EV_STEP: begin
            k_in      = k_ff - CW'(1);
            mul_start = 1'b1;
            mul_a     = acc_ff;
            mul_b     = pt_ff;
            ret_in    = S_EV_ADD;
            state_in  = S_MUL_WT;
         end
         S_EV_ADD: begin
            acc_in   = mul_prod ^ coef_rd_ff;
            state_in = (k_ff == '0) ? S_FINISH : S_EV_STEP;
         end

         // Lagrange term for point i
         S_IP_RDI: begin
            state_in = S_IP_LDI;
         end
         S_IP_LDI: begin
            num_in = FIELD_BITS'(1);
            den_in = FIELD_BITS'(1);
            j_in   = '0;
            if (yi_rd_ff == '0) begin
               // zero share contributes nothing
               if (i_last) begin
                  state_in = S_FINISH;
               end else begin
                  i_in     = i_ff + PCW'(1);
                  state_in = S_IP_RDI;
               end
            end else begin
               state_in = S_IP_JRD;
            end
         end
         S_IP_JRD: begin
            state_in = S_IP_JCHK;
         end
         S_IP_JCHK: begin
            if (j_ff == i_ff) begin
               if (j_last) begin
                  state_in = S_IP_INV0;
               end else begin
                  j_in     = j_ff + PCW'(1);
                  state_in = S_IP_JRD;
               end
            end else begin
               mul_start = 1'b1;
               mul_a     = num_ff;
               mul_b     = pt_ff ^ xj_rd_ff;
               ret_in    = S_IP_NUM;
               state_in  = S_MUL_WT;
            end
         end
         S_IP_NUM: begin
            num_in    = mul_prod;
            mul_start = 1'b1;
            mul_a     = den_ff;
            mul_b     = xi_rd_ff ^ xj_rd_ff;
            ret_in    = S_IP_DEN;
            state_in  = S_MUL_WT;
         end
         S_IP_DEN: begin
            den_in = mul_prod;
            if (j_last) begin
               state_in = S_IP_INV0;
            end else begin
               j_in     = j_ff + PCW'(1);
               state_in = S_IP_JRD;
            end
         end

         // Invert the denominator: product of its squares D^2 .. D^(2^(m-1))
         S_IP_INV0: begin
            sq_in    = den_ff;
            inv_in   = FIELD_BITS'(1);
            ecnt_in  = EW'(FIELD_BITS - 1);
            state_in = S_IP_SQ;
         end
         S_IP_SQ: begin
            mul_start = 1'b1;
            mul_a     = sq_ff;
            mul_b     = sq_ff;
            ret_in    = S_IP_SQD;
            state_in  = S_MUL_WT;
         end
         S_IP_SQD: begin
            sq_in     = mul_prod;
            mul_start = 1'b1;
            mul_a     = inv_ff;
            mul_b     = mul_prod;
            ret_in    = S_IP_INVM;
            state_in  = S_MUL_WT;
         end
         S_IP_INVM: begin
            inv_in   = mul_prod;
            ecnt_in  = ecnt_ff - EW'(1);
            state_in = (ecnt_ff == EW'(1)) ? S_IP_T1 : S_IP_SQ;
         end

         // term = y * num * inv(den), folded into the sum
         S_IP_T1: begin
            mul_start = 1'b1;
            mul_a     = yi_rd_ff;
            mul_b     = num_ff;
            ret_in    = S_IP_T2;
            state_in  = S_MUL_WT;
         end
         S_IP_T2: begin
            mul_start = 1'b1;
            mul_a     = mul_prod;
            mul_b     = inv_ff;
            ret_in    = S_IP_T3;
            state_in  = S_MUL_WT;
         end
         S_IP_T3: begin
            acc_in = acc_ff ^ mul_prod;
            if (i_last) begin
               state_in = S_FINISH;
            end else begin
               i_in     = i_ff + PCW'(1);
               state_in = S_IP_RDI;
            end
         end

         // Hold until the multiplier finishes, then return
         S_MUL_WT: begin
            if (mul_done) begin
               state_in = ret_ff;
            end
         end

         // Present the result beat for one cycle
         S_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_result_in = acc_ff;
            rsp_status_in = status_ff;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      pt_ff         <= pt_in;
      val_ff        <= val_in;
      acc_ff        <= acc_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      sq_ff         <= sq_in;
      inv_ff        <= inv_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      ecnt_ff       <= ecnt_in;
      status_ff     <= status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Coefficient store
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[CA'(slot_ff)] <= val_ff;
      end
      coef_rd_ff <= coef_mem[k_ff[CA-1:0]];
   end

   // Point stores: x read at i and j, y read at i
   always_ff @(posedge clock) begin
      if (pt_we) begin
         xs_mem[count_ff[PA-1:0]] <= pt_ff;
         ys_mem[count_ff[PA-1:0]] <= val_ff;
      end
      xi_rd_ff <= xs_mem[i_ff[PA-1:0]];
      xj_rd_ff <= xs_mem[j_ff[PA-1:0]];
      yi_rd_ff <= ys_mem[i_ff[PA-1:0]];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== hdl/gf2m_share_eval_and_interpolate_top.sv =====
// Top level of the GF(2^m) Shamir share core: threshold register, sequencer, multiplier.
// Depends on gfsi_pkg, gfsi_ctrl and gfsi_mul.
//
// Usage:
//   Input: a command beat is taken at a rising edge with start high and busy low.
//     req_command selects set coefficient, evaluate, add point, interpolate or
//     clear points; req_coef_slot, req_point and req_value carry its operands.
//   Output: every command returns exactly one beat on rsp_result / rsp_status,
//     marked by rsp_valid for one cycle. The receiver cannot stall; a beat that
//     is not taken in its cycle is gone.
//   Configuration: csr_we writes csr_wdata into the coefficient count (threshold)
//     at the edge; write it only while busy is low and no beat is pending.
// Sequence of work per command:
//   set, clear and unused codes go straight to the result beat. Add point
//   compares the new x against each stored x in turn. Evaluate with n
//   coefficients runs n Horner steps through the shared digit-serial multiplier.
//   Interpolate skips a point with a zero share; any other point takes two
//   products per other point, the squarings and products of the inversion
//   and two more products for its term. busy stays high for the whole
//   command; the next one is taken as the result beat is shown.
// Reset: the point count clears, the threshold returns to 2; coefficient and
//   point stores hold no defined contents until written.
module gf2m_share_eval_and_interpolate_top #(
   parameter int FIELD_BITS = 8,
   parameter int MAX_COEFFS = 16,
   parameter int MAX_POINTS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [gfsi_pkg::CMD_WIDTH-1:0]     req_command,
   input  logic [gfsi_pkg::SLOT_WIDTH-1:0]    req_coef_slot,
   input  logic [FIELD_BITS-1:0]              req_point,
   input  logic [FIELD_BITS-1:0]              req_value,
   output logic                               rsp_valid,
   output logic [FIELD_BITS-1:0]              rsp_result,
   output logic [gfsi_pkg::STATUS_WIDTH-1:0]  rsp_status,
   input  logic                               csr_we,
   input  logic [gfsi_pkg::CSR_WIDTH-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_COEFFS + 1);

   logic [gfsi_pkg::CSR_WIDTH-1:0] coeff_count_ff, coeff_count_in;
   logic [CW-1:0]                  coeff_limit;
   logic                           mul_start;
   logic [FIELD_BITS-1:0]          mul_a;
   logic [FIELD_BITS-1:0]          mul_b;
   logic                           mul_done;
   logic [FIELD_BITS-1:0]          mul_prod;

   // Threshold register
   assign coeff_count_in = csr_we ? csr_wdata : coeff_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_count_ff <= gfsi_pkg::COEFF_COUNT_RESET;
      end else begin
         coeff_count_ff <= coeff_count_in;
      end
   end

   // Saturate the count to the coefficient store depth
   assign coeff_limit = (32'(coeff_count_ff) > MAX_COEFFS) ? CW'(MAX_COEFFS)
                                                            : CW'(coeff_count_ff);

   gfsi_ctrl #(
      .FIELD_BITS (FIELD_BITS),
      .MAX_COEFFS (MAX_COEFFS),
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_coef_slot (req_coef_slot),
      .req_point     (req_point),
      .req_value     (req_value),
      .coeff_limit   (coeff_limit),
      .rsp_valid     (rsp_valid),
      .rsp_result    (rsp_result),
      .rsp_status    (rsp_status),
      .mul_start     (mul_start),
      .mul_a         (mul_a),
      .mul_b         (mul_b),
      .mul_done      (mul_done),
      .mul_prod      (mul_prod)
   );

   gfsi_mul #(
      .FIELD_BITS (FIELD_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .mul_start (mul_start),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_done  (mul_done),
      .mul_prod  (mul_prod)
   );

endmodule
